@@ rtl/ccx_pkg.sv @@
// Shared types, constants and register codes for the ChaCha20 stream XOR block.
`timescale 1ns / 1ps
`default_nettype none
package ccx_pkg;

	// Input queue between the front and back parts
	localparam int CCX_Q_DEPTH = 4;
	localparam int CCX_Q_AW    = $clog2(CCX_Q_DEPTH);

	// Block function: 20 rounds, each done as two half quarter-round steps
	localparam int CCX_ROUNDS      = 20;
	localparam int CCX_HALF_STEPS  = 2 * CCX_ROUNDS;
	localparam int CCX_STEP_W      = $clog2(CCX_HALF_STEPS);
	localparam int CCX_BLOCK_BYTES = 64;
	localparam int CCX_OFF_W       = $clog2(CCX_BLOCK_BYTES);

	// "expand 32-byte k"
	localparam logic [31:0] CCX_SIGMA0 = 32'h61707865;
	localparam logic [31:0] CCX_SIGMA1 = 32'h3320646e;
	localparam logic [31:0] CCX_SIGMA2 = 32'h79622d32;
	localparam logic [31:0] CCX_SIGMA3 = 32'h6b206574;

	// Configuration register indexes
	localparam int CCX_CFG_IDX_W = 3;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_KEY_Q0        = 3'd0;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_KEY_Q1        = 3'd1;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_KEY_Q2        = 3'd2;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_KEY_Q3        = 3'd3;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_NONCE_LOW     = 3'd4;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_NONCE_HIGH    = 3'd5;
	localparam logic [CCX_CFG_IDX_W-1:0] CCX_CFG_START_COUNTER = 3'd6;

	// Input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} ccx_in_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} ccx_out_t;

	// Queue entry: input plus its position in the message
	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 last_byte;
		logic                 first;
		logic [CCX_OFF_W-1:0] offset;
	} ccx_qent_t;

	// Configuration registers as one bundle
	typedef struct packed {
		logic [3:0][63:0] key_q;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
		logic [31:0]      start_counter;
	} ccx_cfg_t;

	typedef logic [15:0][31:0] ccx_block_t;

	// Back part to keystream core
	typedef struct packed {
		logic        start;
		logic        abort;
		logic [31:0] ctr;
	} ccx_core_cmd_t;

	// Keystream core status
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] ctr;
	} ccx_core_sts_t;

endpackage
`default_nettype wire

@@ rtl/ccx_core.sv @@
// Iterative ChaCha20 block function: two half quarter-round steps per round.
`timescale 1ns / 1ps
`default_nettype none
module ccx_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccx_pkg::ccx_cfg_t     cfg,
	input  ccx_pkg::ccx_core_cmd_t cmd,
	output ccx_pkg::ccx_core_sts_t sts,
	output ccx_pkg::ccx_block_t   ks
);
	import ccx_pkg::*;

	localparam logic [1:0] CS_IDLE = 2'd0;
	localparam logic [1:0] CS_RUN  = 2'd1;
	localparam logic [1:0] CS_FEED = 2'd2;
	localparam logic [1:0] CS_DONE = 2'd3;

	localparam logic [CCX_STEP_W-1:0] STEP_LAST = CCX_STEP_W'(CCX_HALF_STEPS - 1);

	logic [1:0]            state_q;
	logic [CCX_STEP_W-1:0] step_q;
	logic [31:0]           ctr_q;
	ccx_block_t            w_q;
	ccx_block_t            init;
	ccx_block_t            ld_w;
	ccx_block_t            rnd_w;
	ccx_block_t            ff_w;

	// Initial state for the running job, and for a new job from cmd.ctr
	always_comb begin
		init[0] = CCX_SIGMA0;
		init[1] = CCX_SIGMA1;
		init[2] = CCX_SIGMA2;
		init[3] = CCX_SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = cfg.key_q[i][31:0];
			init[5 + 2 * i] = cfg.key_q[i][63:32];
		end
		init[12] = ctr_q;
		init[13] = cfg.nonce_low[31:0];
		init[14] = cfg.nonce_low[63:32];
		init[15] = cfg.nonce_high;
		ld_w     = init;
		ld_w[12] = cmd.ctr;
	end

	// One half of four parallel quarter rounds (columns or diagonals)
	always_comb begin
		logic       diag;
		logic       half;
		logic [1:0] qb;
		logic [3:0] ia, ib, ic, id;
		logic [31:0] a, b, c, d, a1, b1, c1, d1, x, y;
		diag  = step_q[1];
		half  = step_q[0];
		rnd_w = w_q;
		for (int q = 0; q < 4; q++) begin
			qb = 2'(q);
			ia = {2'b00, qb};
			ib = {2'b01, diag ? qb + 2'd1 : qb};
			ic = {2'b10, diag ? qb + 2'd2 : qb};
			id = {2'b11, diag ? qb + 2'd3 : qb};
			a  = w_q[ia];
			b  = w_q[ib];
			c  = w_q[ic];
			d  = w_q[id];
			a1 = a + b;
			x  = d ^ a1;
			d1 = half ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
			c1 = c + d1;
			y  = b ^ c1;
			b1 = half ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
			rnd_w[ia] = a1;
			rnd_w[ib] = b1;
			rnd_w[ic] = c1;
			rnd_w[id] = d1;
		end
	end

	// Feed-forward add
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			ff_w[i] = w_q[i] + init[i];
		end
	end

	// Job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
			ctr_q   <= '0;
		end else if (cmd.abort) begin
			state_q <= CS_IDLE;
		end else if (cmd.start) begin
			state_q <= CS_RUN;
			step_q  <= '0;
			ctr_q   <= cmd.ctr;
		end else begin
			unique case (state_q)
				CS_RUN: begin
					if (step_q == STEP_LAST) begin
						state_q <= CS_FEED;
					end else begin
						step_q <= step_q + CCX_STEP_W'(1);
					end
				end
				CS_FEED: begin
					state_q <= CS_DONE;
				end
				CS_IDLE: begin
					state_q <= CS_IDLE;
				end
				CS_DONE: begin
					state_q <= CS_DONE;
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

	// Working state
	always_ff @(posedge clk) begin
		if (!cmd.abort && cmd.start) begin
			w_q <= ld_w;
		end else if (state_q == CS_RUN) begin
			w_q <= rnd_w;
		end else if (state_q == CS_FEED) begin
			w_q <= ff_w;
		end
	end

	assign sts.busy = (state_q == CS_RUN) || (state_q == CS_FEED);
	assign sts.done = (state_q == CS_DONE);
	assign sts.ctr  = ctr_q;
	assign ks       = w_q;

endmodule
`default_nettype wire

@@ rtl/ccx_front.sv @@
// Front part: accepts bytes, tags message start and block offset, queues them.
`timescale 1ns / 1ps
`default_nettype none
module ccx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ccx_pkg::ccx_in_t   item,
	output logic               head_valid,
	output ccx_pkg::ccx_qent_t head,
	input  logic               pop
);
	import ccx_pkg::*;

	logic                  in_msg_q;
	logic [CCX_OFF_W-1:0]  off_q;
	ccx_qent_t             q_mem_q [CCX_Q_DEPTH];
	logic [CCX_Q_AW-1:0]   wr_ptr_q;
	logic [CCX_Q_AW-1:0]   rd_ptr_q;
	logic [CCX_Q_AW:0]     cnt_q;
	logic                  push;
	ccx_qent_t             ent;

	assign item_stall = (cnt_q == (CCX_Q_AW + 1)'(CCX_Q_DEPTH));
	assign push       = item_valid && !item_stall;
	assign head_valid = (cnt_q != '0);
	assign head       = q_mem_q[rd_ptr_q];

	// Classify the incoming transaction
	always_comb begin
		ent.data_byte = item.data_byte;
		ent.last_byte = item.last_byte;
		ent.first     = !in_msg_q;
		ent.offset    = in_msg_q ? off_q : '0;
	end

	// Message tracking and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			off_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CCX_Q_AW'(1);
				in_msg_q <= !item.last_byte;
				off_q    <= item.last_byte ? '0 : ent.offset + CCX_OFF_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CCX_Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (CCX_Q_AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (CCX_Q_AW + 1)'(1);
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= ent;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ccx_back.sv @@
// Back part: keystream buffer, core scheduling, XOR and output register.
`timescale 1ns / 1ps
`default_nettype none
module ccx_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  ccx_pkg::ccx_qent_t     head,
	output logic                   pop,
	input  logic [31:0]            start_counter,
	input  logic                   cfg_we,
	output ccx_pkg::ccx_core_cmd_t core_cmd,
	input  ccx_pkg::ccx_core_sts_t core_sts,
	input  ccx_pkg::ccx_block_t    core_ks,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ccx_pkg::ccx_out_t      result
);
	import ccx_pkg::*;

	logic        in_msg_q;
	logic        act_valid_q;
	logic [31:0] ctr_q;
	ccx_block_t  ks_q;
	logic        out_valid_q;
	ccx_out_t    out_q;

	logic [31:0] need_ctr;
	logic [31:0] blk_ctr;
	logic        core_hit;
	logic        ks_avail;
	logic        out_free;
	logic        blk_end;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;

	// Block the core should hold next: next message start, block after the active one, else ctr_q
	always_comb begin
		if (!in_msg_q) begin
			need_ctr = start_counter;
		end else if (act_valid_q) begin
			need_ctr = ctr_q + 32'd1;
		end else begin
			need_ctr = ctr_q;
		end
		core_cmd.abort = cfg_we;
		core_cmd.ctr   = need_ctr;
		core_cmd.start = !(core_sts.busy || core_sts.done) || (core_sts.ctr != need_ctr);
	end

	// Keystream availability for the queue head
	assign blk_ctr  = head.first ? start_counter : ctr_q;
	assign core_hit = core_sts.done && (core_sts.ctr == blk_ctr);
	assign ks_avail = act_valid_q || core_hit;
	assign out_free = !out_valid_q || !result_stall;
	assign pop      = head_valid && ks_avail && out_free;
	assign blk_end  = (head.offset == CCX_OFF_W'(CCX_BLOCK_BYTES - 1));

	// Keystream byte select, little endian within each word
	assign ks_word = act_valid_q ? ks_q[head.offset[CCX_OFF_W-1:2]]
	                             : core_ks[head.offset[CCX_OFF_W-1:2]];
	assign ks_byte = 8'(ks_word >> {head.offset[1:0], 3'b000});

	// Message and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q    <= 1'b0;
			act_valid_q <= 1'b0;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last_byte) begin
					in_msg_q    <= 1'b0;
					act_valid_q <= 1'b0;
				end else begin
					in_msg_q    <= 1'b1;
					act_valid_q <= !blk_end;
					ctr_q       <= blk_end ? blk_ctr + 32'd1 : blk_ctr;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Active keystream block and output payload
	always_ff @(posedge clk) begin
		if (pop && !act_valid_q) begin
			ks_q <= core_ks;
		end
		if (pop) begin
			out_q.out_byte <= head.data_byte ^ ks_byte;
			out_q.out_last <= head.last_byte;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

@@ rtl/chacha20_stream_xor.sv @@
// Top level: ChaCha20 byte stream XOR with configuration registers.
//
//  Channel   Handshake                 Payload
//  input     item_valid / item_stall   item (data_byte, last_byte)
//  output    result_valid / result_stall  result (out_byte, out_last)
//  config    cfg_we                    cfg_index, cfg_data
//
// Sustains one byte per cycle while the output is not stalled and the keystream
// block is ready; a byte passes through the input queue, then the output register.
// The iterative keystream core builds each 64-byte block in 40 half quarter-round
// steps plus the feed-forward add and works on the next block as the current one drains.
// The first byte of a message waits for its keystream block when none is ready:
// after reset, after a config write, or right after the previous message ended.
// Reset clears control and configuration registers only; there is no clearing pass.
// A stalled output holds the output register; the 4-entry input queue keeps
// taking bytes until it fills.
`timescale 1ns / 1ps
`default_nettype none
module chacha20_stream_xor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  ccx_pkg::ccx_in_t                      item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output ccx_pkg::ccx_out_t                     result,
	input  logic                                  cfg_we,
	input  logic [ccx_pkg::CCX_CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                           cfg_data
);
	import ccx_pkg::*;

	ccx_cfg_t      cfg_q;
	logic          head_valid;
	ccx_qent_t     head;
	logic          pop;
	ccx_core_cmd_t core_cmd;
	ccx_core_sts_t core_sts;
	ccx_block_t    core_ks;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CCX_CFG_KEY_Q0:        cfg_q.key_q[0]       <= cfg_data;
				CCX_CFG_KEY_Q1:        cfg_q.key_q[1]       <= cfg_data;
				CCX_CFG_KEY_Q2:        cfg_q.key_q[2]       <= cfg_data;
				CCX_CFG_KEY_Q3:        cfg_q.key_q[3]       <= cfg_data;
				CCX_CFG_NONCE_LOW:     cfg_q.nonce_low      <= cfg_data;
				CCX_CFG_NONCE_HIGH:    cfg_q.nonce_high     <= cfg_data[31:0];
				CCX_CFG_START_COUNTER: cfg_q.start_counter  <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	ccx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ccx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (core_cmd),
		.sts    (core_sts),
		.ks     (core_ks)
	);

	ccx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.start_counter (cfg_q.start_counter),
		.cfg_we        (cfg_we),
		.core_cmd      (core_cmd),
		.core_sts      (core_sts),
		.core_ks       (core_ks),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

`ifndef SYNTHESIS
	// A config write drops any prefetched or running keystream job
	a_cfg_aborts_core: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !core_sts.busy && !core_sts.done)
		else $error("keystream job survived a config write");

	// A started job runs for the requested block counter
	a_start_loads_ctr: assert property (@(posedge clk) disable iff (!arst_n)
		arst_n && core_cmd.start && !core_cmd.abort |=>
			core_sts.busy && core_sts.ctr == $past(core_cmd.ctr))
		else $error("keystream job did not start as requested");

	// A finished block stays put until replaced
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		core_sts.done && !core_cmd.start && !core_cmd.abort |=>
			core_sts.done && $stable(core_sts.ctr) && $stable(core_ks))
		else $error("finished keystream block changed");
`endif

endmodule
`default_nettype wire
